### src/matrix_multiply_assert.svh
// Assertion macros used by the matrix multiply checker.
// Each macro expects clk and rst to be visible where it is used.
`ifndef MATRIX_MULTIPLY_ASSERT_SVH
`define MATRIX_MULTIPLY_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define MM_ASSERT_SAME(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("matrix_multiply assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define MM_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("matrix_multiply assertion failed");

`endif

### src/mm_pkg.sv
// Shared types, constants and helper functions for the matrix multiply block.
// Used by every module of the block and by its checker; depends on nothing.
`timescale 1ns / 1ps

package mm_pkg;

  // Largest matrix dimension that the element stores hold.
  localparam int unsigned MAX_DIM = 8;

  // Field widths of the ports.
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned ROW_W     = 3;
  localparam int unsigned COL_W     = 3;
  localparam int unsigned VAL_W     = 16;
  localparam int unsigned PROD_W    = 36;
  localparam int unsigned CFG_W     = 4;
  localparam int unsigned CFG_IDX_W = 2;

  // Derived widths.
  localparam int unsigned IDX_W     = $clog2(MAX_DIM);
  localparam int unsigned MEM_DEPTH = MAX_DIM * MAX_DIM;
  localparam int unsigned ADDR_W    = $clog2(MEM_DEPTH);
  localparam int unsigned MUL_W     = 2 * VAL_W;
  localparam int unsigned POS_W     = ROW_W + 1;

  // Dimension register value after reset.
  localparam logic [CFG_W-1:0] DIM_RESET = CFG_W'(8);

  // Item kinds carried on the input channel.
  typedef enum logic [KIND_W-1:0] {
    KIND_WR_A = 2'd0,
    KIND_WR_B = 2'd1,
    KIND_RUN  = 2'd2
  } kind_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_A_ROWS    = 2'd0,
    REG_INNER_DIM = 2'd1,
    REG_B_COLS    = 2'd2
  } reg_idx_t;

  // Control that travels with each pair of operands through the datapath.
  typedef struct packed {
    logic valid;
    logic first;
    logic lastk;
  } tag_t;

  // Write request into the element stores.
  typedef struct packed {
    logic              en_a;
    logic              en_b;
    logic [ADDR_W-1:0] addr;
  } wr_t;

  // Last loop index for a dimension register, with zero read as one and
  // anything above the store size read as the store size.
  function automatic logic [IDX_W-1:0] dim_last(input logic [CFG_W-1:0] v);
    logic [IDX_W-1:0] r;
    if (v == '0) begin
      r = '0;
    end else if (v > CFG_W'(MAX_DIM)) begin
      r = IDX_W'(MAX_DIM - 1);
    end else begin
      r = IDX_W'(v - 1'b1);
    end
    return r;
  endfunction

  // True when an element position lies inside the stores.
  function automatic logic in_range(input logic [ROW_W-1:0] r,
                                    input logic [COL_W-1:0] c);
    return (POS_W'(r) < POS_W'(MAX_DIM)) && (POS_W'(c) < POS_W'(MAX_DIM));
  endfunction

  // Row-major store address of an element.
  function automatic logic [ADDR_W-1:0] elem_addr(input logic [IDX_W-1:0] r,
                                                  input logic [IDX_W-1:0] c);
    return ADDR_W'(ADDR_W'(r) * ADDR_W'(MAX_DIM)) + ADDR_W'(c);
  endfunction

endpackage

### src/matrix_multiply.sv
// Matrix multiply top level: element stores, loop sequencer and result register.
// Depends on mm_pkg, mm_store and mm_mac.
`timescale 1ns / 1ps

// An input item of kind write-A or write-B stores one Q8.8 element, so loads stream
// at one item per cycle while the sequencer is idle. A compute item holds the input
// channel while the sequencer walks the result in row-major order; each result
// element reads its inner_dim operand pairs from the two single-port-read stores,
// one pair per cycle, and then waits for the read, multiply and accumulate
// registers. The sequencer also waits before each result until the output
// register is free. Dimension registers read as 1 when zero and as 8 above 8.
// Store entries hold garbage until written; there is no clearing pass.
module matrix_multiply
  import mm_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  // Configuration write channel.
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  // Input item channel.
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [KIND_W-1:0]        kind,
  input  logic [ROW_W-1:0]         row,
  input  logic [COL_W-1:0]         col,
  input  logic signed [VAL_W-1:0]  value,
  // Result item channel.
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [ROW_W-1:0]         out_row,
  output logic [COL_W-1:0]         out_col,
  output logic signed [PROD_W-1:0] product,
  output logic                     last
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_ISSUE,
    ST_WAIT
  } state_t;

  state_t            state;
  logic [CFG_W-1:0]  a_rows;
  logic [CFG_W-1:0]  inner_dim;
  logic [CFG_W-1:0]  b_cols;
  logic [IDX_W-1:0]  i;
  logic [IDX_W-1:0]  j;
  logic [IDX_W-1:0]  k;
  logic [IDX_W-1:0]  ilast;
  logic [IDX_W-1:0]  jlast;
  logic [IDX_W-1:0]  klast;
  tag_t              tag_issue;
  tag_t              tag_r;
  wr_t               wr;
  logic              in_accept;
  logic [VAL_W-1:0]  rd_a_data;
  logic [VAL_W-1:0]  rd_b_data;
  logic [PROD_W-1:0] sum;
  logic              sum_valid;
  logic              out_free;
  logic              elem_last;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign elem_last = (i == ilast) && (j == jlast);

  // Element writes are only taken while idle, so a following compute item
  // always reads the stored value and no forwarding is needed.
  always_comb begin
    wr.en_a = in_accept && (kind == KIND_WR_A) && in_range(row, col);
    wr.en_b = in_accept && (kind == KIND_WR_B) && in_range(row, col);
    wr.addr = elem_addr(IDX_W'(row), IDX_W'(col));
  end

  // One operand pair is issued per cycle in the issue state.
  always_comb begin
    tag_issue.valid = (state == ST_ISSUE);
    tag_issue.first = (k == '0);
    tag_issue.lastk = (k == klast);
  end

  mm_store u_store (
    .clk       (clk),
    .wr        (wr),
    .wr_data   (value),
    .rd_a_addr (elem_addr(i, k)),
    .rd_b_addr (elem_addr(k, j)),
    .rd_a_data (rd_a_data),
    .rd_b_data (rd_b_data)
  );

  mm_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .a_data    (rd_a_data),
    .b_data    (rd_b_data),
    .tag_in    (tag_r),
    .sum       (sum),
    .sum_valid (sum_valid)
  );

  // Sequencer, configuration registers and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      tag_r     <= '0;
      a_rows    <= DIM_RESET;
      inner_dim <= DIM_RESET;
      b_cols    <= DIM_RESET;
    end else begin
      tag_r <= tag_issue;
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_A_ROWS:    a_rows    <= cfg_data;
          REG_INNER_DIM: inner_dim <= cfg_data;
          REG_B_COLS:    b_cols    <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        ST_IDLE: begin
          if (in_accept && (kind == KIND_RUN)) begin
            ilast <= dim_last(a_rows);
            klast <= dim_last(inner_dim);
            jlast <= dim_last(b_cols);
            i     <= '0;
            j     <= '0;
            k     <= '0;
            state <= ST_START;
          end
        end
        ST_START: begin
          // Start a dot product only when its result has somewhere to go.
          if (out_free) begin
            state <= ST_ISSUE;
          end
        end
        ST_ISSUE: begin
          if (k == klast) begin
            k     <= '0;
            state <= ST_WAIT;
          end else begin
            k <= k + 1'b1;
          end
        end
        ST_WAIT: begin
          if (sum_valid) begin
            out_valid <= 1'b1;
            out_row   <= ROW_W'(i);
            out_col   <= COL_W'(j);
            product   <= sum;
            last      <= elem_last;
            if (elem_last) begin
              state <= ST_IDLE;
            end else begin
              if (j == jlast) begin
                j <= '0;
                i <= i + 1'b1;
              end else begin
                j <= j + 1'b1;
              end
              state <= ST_START;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

### src/mm_store.sv
// Element stores for the A and B matrices, one synchronous memory each.
// Depends on mm_pkg for widths and the write request type.
`timescale 1ns / 1ps

module mm_store
  import mm_pkg::*;
(
  input  logic              clk,
  input  wr_t               wr,
  input  logic [VAL_W-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_a_addr,
  input  logic [ADDR_W-1:0] rd_b_addr,
  output logic [VAL_W-1:0]  rd_a_data,
  output logic [VAL_W-1:0]  rd_b_data
);

  logic [VAL_W-1:0] a_mem [MEM_DEPTH];
  logic [VAL_W-1:0] b_mem [MEM_DEPTH];

  // Store A: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr.en_a) begin
      a_mem[wr.addr] <= wr_data;
    end
    rd_a_data <= a_mem[rd_a_addr];
  end

  // Store B: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr.en_b) begin
      b_mem[wr.addr] <= wr_data;
    end
    rd_b_data <= b_mem[rd_b_addr];
  end

endmodule

### src/mm_mac.sv
// Multiply-accumulate datapath: a registered 16x16 multiply and a 36-bit accumulator.
// Depends on mm_pkg for widths and the operand tag type.
`timescale 1ns / 1ps

module mm_mac
  import mm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic [VAL_W-1:0]  a_data,
  input  logic [VAL_W-1:0]  b_data,
  input  tag_t              tag_in,
  output logic [PROD_W-1:0] sum,
  output logic              sum_valid
);

  logic signed [MUL_W-1:0]  prod;
  logic signed [PROD_W-1:0] acc;
  logic signed [PROD_W-1:0] prod_ext;
  tag_t                     tag_m;

  // Control follows the product register; the sum is flagged after the last term.
  always_ff @(posedge clk) begin
    if (rst) begin
      tag_m     <= '0;
      sum_valid <= 1'b0;
    end else begin
      tag_m     <= tag_in;
      sum_valid <= tag_m.valid && tag_m.lastk;
    end
  end

  assign prod_ext = {{(PROD_W - MUL_W){prod[MUL_W-1]}}, prod};

  // Product register, then accumulate; the first term of a dot product restarts the sum.
  always_ff @(posedge clk) begin
    prod <= $signed(a_data) * $signed(b_data);
    if (tag_m.valid) begin
      acc <= tag_m.first ? prod_ext : acc + prod_ext;
    end
  end

  assign sum = acc;

endmodule

### src/mm_checker.sv
// Port-level checker for the matrix multiply block, bound to its top level.
// Depends on mm_pkg and the assertion macros in matrix_multiply_assert.svh.
`timescale 1ns / 1ps
`include "matrix_multiply_assert.svh"

module mm_checker
  import mm_pkg::*;
(
  input logic                     clk,
  input logic                     rst,
  input logic                     in_valid,
  input logic                     in_stall,
  input logic [KIND_W-1:0]        kind,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic [ROW_W-1:0]         out_row,
  input logic [COL_W-1:0]         out_col,
  input logic signed [PROD_W-1:0] product,
  input logic                     last
);

  // A stalled result item stays offered with the same contents.
  `MM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(product) && $stable(last))

  // A stalled result item keeps its position in the result.
  `MM_ASSERT_NEXT(a_out_pos_hold, out_valid && out_stall, $stable(out_row) && $stable(out_col))

  // An item other than a compute item leaves the block ready in the next cycle.
  `MM_ASSERT_NEXT(a_load_stream, in_valid && !in_stall && kind != KIND_RUN, !in_stall)

  // A compute item holds the input channel while the run proceeds.
  `MM_ASSERT_NEXT(a_run_holds, in_valid && !in_stall && kind == KIND_RUN, in_stall)

  // A result that is not the last of its run means the run is still going.
  `MM_ASSERT_SAME(a_mid_run_busy, out_valid && !last, in_stall)

endmodule

bind matrix_multiply mm_checker u_mm_checker (.*);

### dv/tb.sv
// Self-checking testbench for matrix_multiply: a directed table, a store fill, then random phases.
// Depends on mm_pkg and the matrix_multiply RTL; products are predicted in-line.
`timescale 1ns / 1ps

module tb
  import mm_pkg::*;
();

  // Codes that the package leaves unnamed.
  localparam logic [KIND_W-1:0]    KIND_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NONE    = 2'd3;

  localparam int RANDOM_ITEMS = 360;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES  = 300;

  // One result element of a multiply.
  typedef struct packed {
    logic [ROW_W-1:0]         r;
    logic [COL_W-1:0]         c;
    logic signed [PROD_W-1:0] p;
    logic                     l;
  } product_item_t;

  // One row of the directed table: a register write or an input item.
  typedef struct {
    bit                       is_cfg;
    logic [1:0]               code;
    logic [ROW_W-1:0]         r;
    logic [COL_W-1:0]         c;
    logic [VAL_W-1:0]         v;
    bit                       typed;
    logic signed [PROD_W-1:0] p;
  } stim_row_t;

  logic                     clk;
  logic                     rst;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [CFG_W-1:0]         cfg_data;
  logic                     in_valid;
  logic                     in_stall;
  logic [KIND_W-1:0]        kind;
  logic [ROW_W-1:0]         row;
  logic [COL_W-1:0]         col;
  logic signed [VAL_W-1:0]  value;
  logic                     out_valid;
  logic                     out_stall;
  logic [ROW_W-1:0]         out_row;
  logic [COL_W-1:0]         out_col;
  logic signed [PROD_W-1:0] product;
  logic                     last;

  // Side band that travels with an item whose single result is typed in the table.
  logic                     typed_valid;
  logic signed [PROD_W-1:0] typed_product;

  // Predictor state.
  logic signed [VAL_W-1:0]  a_elems [MEM_DEPTH];
  logic signed [VAL_W-1:0]  b_elems [MEM_DEPTH];
  logic [CFG_W-1:0]         rows_reg;
  logic [CFG_W-1:0]         inner_reg;
  logic [CFG_W-1:0]         cols_reg;
  product_item_t            expected_products [$];
  int                       mismatches = 0;

  stim_row_t                directed_tab [$];

  matrix_multiply u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .kind      (kind),
    .row       (row),
    .col       (col),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_row   (out_row),
    .out_col   (out_col),
    .product   (product),
    .last      (last)
  );

  // Clock with a 2 ns period.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Overall limit on the run.
  initial begin
    #2_000_000;
    $display("FAIL matrix_multiply");
    $finish;
  end

  // A dimension register reads as 1 when zero and as MAX_DIM above it.
  function automatic int eff_dim(input logic [CFG_W-1:0] v);
    if (v == '0) return 1;
    if (v > CFG_W'(MAX_DIM)) return MAX_DIM;
    return int'(v);
  endfunction

  // Queues every result element of one multiply in row-major order.
  function automatic void predict_products();
    int            nr;
    int            nk;
    int            nc;
    longint        acc;
    product_item_t e;
    nr = eff_dim(rows_reg);
    nk = eff_dim(inner_reg);
    nc = eff_dim(cols_reg);
    for (int i = 0; i < nr; i++) begin
      for (int j = 0; j < nc; j++) begin
        acc = 0;
        for (int k = 0; k < nk; k++) begin
          acc += longint'(a_elems[i * MAX_DIM + k]) * longint'(b_elems[k * MAX_DIM + j]);
        end
        e.r = ROW_W'(i);
        e.c = COL_W'(j);
        e.p = acc[PROD_W-1:0];
        e.l = (i == nr - 1) && (j == nc - 1);
        expected_products.insert(expected_products.size(), e);
      end
    end
  endfunction

  // Tracks accepted items and register writes, and checks every accepted result.
  always @(posedge clk) begin
    product_item_t exp_item;
    product_item_t typed_item;
    if (rst) begin
      rows_reg  = DIM_RESET;
      inner_reg = DIM_RESET;
      cols_reg  = DIM_RESET;
    end else begin
      if (in_valid && !in_stall) begin
        if (kind == KIND_WR_A) begin
          a_elems[int'(row) * MAX_DIM + int'(col)] = value;
        end else if (kind == KIND_WR_B) begin
          b_elems[int'(row) * MAX_DIM + int'(col)] = value;
        end else if (kind == KIND_RUN) begin
          if (typed_valid) begin
            typed_item.r = '0;
            typed_item.c = '0;
            typed_item.p = typed_product;
            typed_item.l = 1'b1;
            expected_products.insert(expected_products.size(), typed_item);
          end else begin
            predict_products();
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_A_ROWS:    rows_reg  = cfg_data;
          REG_INNER_DIM: inner_reg = cfg_data;
          REG_B_COLS:    cols_reg  = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_products.size() == 0) begin
          $display("%0t: unexpected result row %0d col %0d product %0d last %0d",
                   $time, out_row, out_col, product, last);
          mismatches++;
        end else begin
          exp_item = expected_products.pop_front();
          if (out_row !== exp_item.r) begin
            $display("%0t: out_row expected %0d actual %0d", $time, exp_item.r, out_row);
            mismatches++;
          end
          if (out_col !== exp_item.c) begin
            $display("%0t: out_col expected %0d actual %0d", $time, exp_item.c, out_col);
            mismatches++;
          end
          if (product !== exp_item.p) begin
            $display("%0t: product expected %0d actual %0d", $time, exp_item.p, product);
            mismatches++;
          end
          if (last !== exp_item.l) begin
            $display("%0t: last expected %0d actual %0d", $time, exp_item.l, last);
            mismatches++;
          end
        end
      end
    end
  end

  // Result side: random stalls, a quiet window, and one long hold-off while the
  // block is busy and the sender is offering an item.
  initial begin
    int cyc;
    bit held;
    cyc = 0;
    held = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (!held && cyc > 500 && in_valid && in_stall && out_valid) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        cyc += HOLD_CYCLES;
      end else if (cyc >= 1000 && cyc < 3000) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < 7);
      end
    end
  end

  // Directed table rows.
  function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_W-1:0] d);
    stim_row_t s;
    s.is_cfg = 1'b1;
    s.code   = idx;
    s.r      = '0;
    s.c      = '0;
    s.v      = VAL_W'(d);
    s.typed  = 1'b0;
    s.p      = '0;
    directed_tab.insert(directed_tab.size(), s);
  endfunction

  function automatic void add_item(input logic [KIND_W-1:0] k, input logic [ROW_W-1:0] r,
                                   input logic [COL_W-1:0] c, input logic [VAL_W-1:0] v);
    stim_row_t s;
    s.is_cfg = 1'b0;
    s.code   = k;
    s.r      = r;
    s.c      = c;
    s.v      = v;
    s.typed  = 1'b0;
    s.p      = '0;
    directed_tab.insert(directed_tab.size(), s);
  endfunction

  function automatic void add_typed_run(input logic signed [PROD_W-1:0] p);
    stim_row_t s;
    s.is_cfg = 1'b0;
    s.code   = KIND_RUN;
    s.r      = '0;
    s.c      = '0;
    s.v      = '0;
    s.typed  = 1'b1;
    s.p      = p;
    directed_tab.insert(directed_tab.size(), s);
  endfunction

  // Element values lean toward the extremes now and then.
  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'hffff;
      3: return ($urandom_range(0, 1) != 0) ? 16'h0000 : 16'h0100;
      default: return VAL_W'($urandom);
    endcase
  endfunction

  // Dimensions are mostly small, with the out-of-range values now and then.
  function automatic logic [CFG_W-1:0] pick_dim();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 60) return CFG_W'($urandom_range(1, 3));
    if (sel < 85) return CFG_W'($urandom_range(0, 15));
    case ($urandom_range(0, 3))
      0: return 4'd0;
      1: return 4'd1;
      2: return 4'd8;
      default: return 4'd15;
    endcase
  endfunction

  // Offers one item and returns at the edge where it is accepted; valid stays high.
  task automatic send_item(input logic [KIND_W-1:0] k, input logic [ROW_W-1:0] r,
                           input logic [COL_W-1:0] c, input logic [VAL_W-1:0] v,
                           input bit has_typed, input logic signed [PROD_W-1:0] tp,
                           input bit may_idle);
    int gap;
    gap = 0;
    if (may_idle && $urandom_range(0, 99) < 5) gap = $urandom_range(1, 2);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    kind          <= k;
    row           <= r;
    col           <= c;
    value         <= v;
    typed_valid   <= has_typed;
    typed_product <= tp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Stops offering items and waits until every expected result has come.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (expected_products.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes one register; valid stays high for a following write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_dims(input logic [CFG_W-1:0] nr, input logic [CFG_W-1:0] nk,
                          input logic [CFG_W-1:0] nc);
    wait_for_drain();
    write_reg(REG_A_ROWS, nr);
    write_reg(REG_INNER_DIM, nk);
    write_reg(REG_B_COLS, nc);
    cfg_valid <= 1'b0;
  endtask

  // Stimulus: reset, the directed table, a fill of both stores, then random phases.
  initial begin
    int n_rand;
    int n_phase;
    int plen;
    int sel;
    bit quiet;
    rst           = 1'b1;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    in_valid      = 1'b0;
    kind          = '0;
    row           = '0;
    col           = '0;
    value         = '0;
    typed_valid   = 1'b0;
    typed_product = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // One by one by one: unit, most negative squared, mixed extremes.
    add_cfg(REG_A_ROWS, 4'd1);
    add_cfg(REG_INNER_DIM, 4'd1);
    add_cfg(REG_B_COLS, 4'd1);
    add_item(KIND_WR_A, 3'd0, 3'd0, 16'h0100);
    add_item(KIND_WR_B, 3'd0, 3'd0, 16'h0100);
    add_typed_run(36'sd65536);
    add_item(KIND_WR_A, 3'd0, 3'd0, 16'h8000);
    add_item(KIND_WR_B, 3'd0, 3'd0, 16'h8000);
    add_typed_run(36'sd1073741824);
    add_item(KIND_WR_B, 3'd0, 3'd0, 16'h7fff);
    add_typed_run(-36'sd1073709056);
    // The unused kind must not touch the store.
    add_item(KIND_UNUSED, 3'd0, 3'd0, 16'h0100);
    add_typed_run(-36'sd1073709056);
    add_item(KIND_WR_A, 3'd7, 3'd7, 16'h7fff);
    add_item(KIND_WR_B, 3'd7, 3'd7, 16'h8000);
    // A register index past the list is ignored; zero dimensions read as one.
    add_cfg(REG_NONE, 4'd15);
    add_cfg(REG_A_ROWS, 4'd0);
    add_cfg(REG_INNER_DIM, 4'd0);
    add_cfg(REG_B_COLS, 4'd2);
    add_item(KIND_WR_B, 3'd0, 3'd1, 16'hffff);
    add_item(KIND_RUN, 3'd7, 3'd7, 16'hffff);

    foreach (directed_tab[i]) begin
      if (directed_tab[i].is_cfg) begin
        wait_for_drain();
        write_reg(directed_tab[i].code, directed_tab[i].v[CFG_W-1:0]);
        cfg_valid <= 1'b0;
      end else begin
        send_item(directed_tab[i].code, directed_tab[i].r, directed_tab[i].c,
                  directed_tab[i].v, directed_tab[i].typed, directed_tab[i].p, 1'b1);
      end
    end

    // Write every entry of both stores so that any later multiply reads written data.
    n_rand = 0;
    for (int i = 0; i < 2 * MEM_DEPTH; i++) begin
      send_item((i % 2 != 0) ? KIND_WR_B : KIND_WR_A, ROW_W'((i / 2) / MAX_DIM),
                COL_W'((i / 2) % MAX_DIM), pick_value(), 1'b0, '0, 1'b1);
      n_rand++;
    end

    // Random phases, each under its own dimension setting and ending in a multiply.
    n_phase = 0;
    while (n_rand < RANDOM_ITEMS) begin
      case (n_phase)
        0: set_dims(4'd8, 4'd8, 4'd8);
        1: set_dims(4'd15, 4'd15, 4'd15);
        2: set_dims(4'd0, 4'd0, 4'd0);
        3: set_dims(4'd1, 4'd8, 4'd1);
        4: set_dims(4'd8, 4'd1, 4'd8);
        default: set_dims(pick_dim(), pick_dim(), pick_dim());
      endcase
      plen = $urandom_range(6, 24);
      for (int j = 0; j < plen; j++) begin
        // The first two phases carry a full-size multiply with items queued behind it.
        sel = (n_phase < 2 && j == 3) ? 10 : $urandom_range(0, 99);
        quiet = (n_rand >= 150) && (n_rand < 230);
        if (sel < 5) begin
          send_item(KIND_UNUSED, ROW_W'($urandom), COL_W'($urandom), pick_value(),
                    1'b0, '0, !quiet);
        end else if (sel < 13) begin
          send_item(KIND_RUN, ROW_W'($urandom), COL_W'($urandom), pick_value(),
                    1'b0, '0, !quiet);
          n_rand++;
        end else begin
          send_item(($urandom_range(0, 1) != 0) ? KIND_WR_B : KIND_WR_A, ROW_W'($urandom),
                    COL_W'($urandom), pick_value(), 1'b0, '0, !quiet);
          n_rand++;
        end
      end
      send_item(KIND_RUN, ROW_W'($urandom), COL_W'($urandom), pick_value(), 1'b0, '0, 1'b1);
      n_rand++;
      n_phase++;
    end

    wait_for_drain();
    if (mismatches == 0 && expected_products.size() == 0) begin
      $display("PASS matrix_multiply");
    end else begin
      $display("FAIL matrix_multiply");
    end
    $finish;
  end

endmodule
